FILE: hw/rtl/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

  // Receive buffer depth and the widths that follow from it.
  localparam int RX_DEPTH = 64;
  localparam int ADDR_W   = $clog2(RX_DEPTH);
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);

  localparam logic [7:0]       FN_READ_COILS   = 8'h01;
  localparam logic [7:0]       NODE_ADDR_RESET = 8'h01;
  localparam logic [CNT_W-1:0] MIN_FRAME       = CNT_W'(5);
  localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY        = 16'hA001;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_COIL   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_TIMEOUT    = 3'd1,
    STAT_SHORT      = 3'd2,
    STAT_CRC        = 3'd3,
    STAT_ID_FN      = 3'd4,
    STAT_BYTE_COUNT = 3'd5,
    STAT_OVERFLOW   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX,
    S_CHECK,
    S_RD,
    S_COIL,
    S_STATUS
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ld_start;
    logic    rx_feed;
    logic    emit_tx;
    logic    set_status;
    status_t status_code;
    logic    coil_rd;
    logic    emit_coil;
    logic    emit_status;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic    slot_free;
    logic    awaiting;
    logic    tx_last;
    status_t check_code;
    logic    coil_none;
    logic    coil_last;
  } dp_stat_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mrc_if.sv
`timescale 1ns / 1ps

// Input word channel.
interface mrc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] start_addr;
  logic [7:0] quantity;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output cmd, output start_addr, output quantity,
                  output rx_byte, output rx_last, input ready);
  modport sink (input valid, input cmd, input start_addr, input quantity,
                input rx_byte, input rx_last, output ready);
endinterface

// Result word channel.
interface mrc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic [4:0] coil_group;
  logic [7:0] coil_bits;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output coil_group,
                  output coil_bits, output status, output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input coil_group,
                input coil_bits, input status, input last, output ready);
endinterface

FILE: hw/rtl/modbus_rtu_read_coils_master_unit.sv
`timescale 1ns / 1ps

// Master side of a Modbus RTU read-coils exchange.
// The item channel carries command words: a start (coil address and quantity),
// one received reply byte (with a flag on the final byte), or a reply timeout.
// The result channel carries request bytes to transmit, packed coil groups and
// a closing status word; the last flag marks the final word of each run.
// The slave address register is to be written through cfg_wr_en / cfg_wr_data only
// while idle, by the user; the block itself does not enforce this.
// A start is taken and its eight request bytes follow one per cycle while the
// receiver keeps up. A reply byte that is not the last is taken with no result.
// The last reply byte leads to a check, then a buffer read and an output write
// for each of up to 32 coil groups, then the status word; the single read port
// of the receive buffer sets that read-then-write step. A timeout yields its status.
// The block takes no new word while it is sending results, but it does take one
// while the last result still waits in the output register.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Synchronous reset returns to idle with no reply outstanding,
// the running CRC at 0xFFFF and the slave address at 1; no buffer clearing pass.
module modbus_rtu_read_coils_master_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  mrc_item_if.sink     item,
  mrc_result_if.source result
);
  import mrc_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // The controller sequences transmit, check and coil emission; the datapath
  // holds the CRC, the receive buffer and the output register.
  mrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_cmd   (item.cmd),
    .item_last  (item.rx_last),
    .stat       (stat),
    .ctl        (ctl)
  );

  mrc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start_addr     (item.start_addr),
    .quantity       (item.quantity),
    .rx_byte        (item.rx_byte),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_kind       (result.kind),
    .out_tx_byte    (result.tx_byte),
    .out_coil_group (result.coil_group),
    .out_coil_bits  (result.coil_bits),
    .out_status     (result.status),
    .out_last       (result.last)
  );

  // A start keeps the item channel closed while the request goes out.
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.cmd == CMD_START) |=> !item.ready)
    else $error("item accepted right after a start");

  // Every status word closes its run.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_STATUS) |-> result.last)
    else $error("status word without last flag");

  // Coil groups never end a run and carry no transmit byte.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_COIL) |-> (!result.last && result.tx_byte == 8'h00))
    else $error("malformed coil group word");

endmodule

FILE: hw/rtl/mrc_ctrl.sv
`timescale 1ns / 1ps

module mrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        item_cmd,
  input  logic              item_last,
  input  mrc_pkg::dp_stat_t stat,
  output mrc_pkg::ctrl_cmd_t ctl
);
  import mrc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          case (item_cmd)
            CMD_START: begin
              ctl.ld_start = 1'b1;
              state_next   = S_TX;
            end
            CMD_RX_BYTE: begin
              if (stat.awaiting) begin
                ctl.rx_feed = 1'b1;
                if (item_last) begin
                  state_next = S_CHECK;
                end
              end
            end
            CMD_TIMEOUT: begin
              if (stat.awaiting) begin
                ctl.set_status  = 1'b1;
                ctl.status_code = STAT_TIMEOUT;
                state_next      = S_STATUS;
              end
            end
            default: ;
          endcase
        end
      end
      S_TX: begin
        ctl.emit_tx = 1'b1;
        if (stat.slot_free && stat.tx_last) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat.check_code != STAT_OK) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = stat.check_code;
          state_next      = S_STATUS;
        end else if (stat.coil_none) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = STAT_OK;
          state_next      = S_STATUS;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        ctl.coil_rd = 1'b1;
        state_next  = S_COIL;
      end
      S_COIL: begin
        ctl.emit_coil = 1'b1;
        if (stat.slot_free) begin
          if (stat.coil_last) begin
            ctl.set_status  = 1'b1;
            ctl.status_code = STAT_OK;
            state_next      = S_STATUS;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_STATUS: begin
        ctl.emit_status = 1'b1;
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mrc_dp.sv
`timescale 1ns / 1ps

module mrc_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [7:0]         start_addr,
  input  logic [7:0]         quantity,
  input  logic [7:0]         rx_byte,
  input  mrc_pkg::ctrl_cmd_t ctl,
  output mrc_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic [4:0]         out_coil_group,
  output logic [7:0]         out_coil_bits,
  output logic [2:0]         out_status,
  output logic               out_last
);
  import mrc_pkg::*;

  logic [7:0]       node_addr;
  logic [7:0]       coil_addr;
  logic [7:0]       pending_qty;
  logic [15:0]      crc;
  logic [CNT_W-1:0] rx_count;
  logic             rx_overflow;
  logic             awaiting;
  logic [7:0]       hdr_id;
  logic [7:0]       hdr_fn;
  logic [7:0]       hdr_count;
  logic [2:0]       tx_idx;
  logic [4:0]       coil_k;
  status_t          stat_code;
  logic [7:0]       rx_store [RX_DEPTH];
  logic [7:0]       rd_data;

  logic [8:0]  qty_sum;
  logic [5:0]  nbytes;
  logic [7:0]  tx_b;
  logic [7:0]  coil_left;
  logic [7:0]  coil_masked;
  logic        slot_free;
  logic        tx_fire;
  logic        coil_fire;
  logic        status_fire;
  status_t     check_code;

  assign qty_sum = {1'b0, pending_qty} + 9'd7;
  assign nbytes  = qty_sum[8:3];

  assign slot_free   = !out_valid || out_ready;
  assign tx_fire     = ctl.emit_tx && slot_free;
  assign coil_fire   = ctl.emit_coil && slot_free;
  assign status_fire = ctl.emit_status && slot_free;

  always_comb begin
    case (tx_idx)
      3'd0:    tx_b = node_addr;
      3'd1:    tx_b = FN_READ_COILS;
      3'd3:    tx_b = coil_addr;
      3'd5:    tx_b = pending_qty;
      3'd6:    tx_b = crc[7:0];
      3'd7:    tx_b = crc[15:8];
      default: tx_b = 8'h00;
    endcase
  end

  // Frame checks in priority order.
  always_comb begin
    if (rx_overflow) begin
      check_code = STAT_OVERFLOW;
    end else if (rx_count < MIN_FRAME) begin
      check_code = STAT_SHORT;
    end else if (crc != 16'h0000) begin
      check_code = STAT_CRC;
    end else if (hdr_id != node_addr || hdr_fn != FN_READ_COILS) begin
      check_code = STAT_ID_FN;
    end else if (hdr_count != {2'b00, nbytes} ||
                 rx_count != CNT_W'(nbytes) + MIN_FRAME) begin
      check_code = STAT_BYTE_COUNT;
    end else begin
      check_code = STAT_OK;
    end
  end

  // Coils past the requested quantity are cleared in the final group.
  assign coil_left   = pending_qty - {coil_k, 3'b000};
  assign coil_masked = (coil_left < 8'd8) ? (rd_data & ~(8'hFF << coil_left[2:0])) : rd_data;

  always_comb begin
    stat.slot_free  = slot_free;
    stat.awaiting   = awaiting;
    stat.tx_last    = (tx_idx == 3'd7);
    stat.check_code = check_code;
    stat.coil_none  = (nbytes == 6'd0);
    stat.coil_last  = ({1'b0, coil_k} + 6'd1 == nbytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr   <= NODE_ADDR_RESET;
      crc         <= CRC_INIT;
      rx_count    <= '0;
      rx_overflow <= 1'b0;
      awaiting    <= 1'b0;
      pending_qty <= 8'h00;
      tx_idx      <= 3'd0;
      coil_k      <= 5'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_addr <= cfg_wr_data;
      end

      if (ctl.ld_start) begin
        coil_addr   <= start_addr;
        pending_qty <= quantity;
        crc         <= CRC_INIT;
        rx_count    <= '0;
        rx_overflow <= 1'b0;
        awaiting    <= 1'b1;
        tx_idx      <= 3'd0;
        coil_k      <= 5'd0;
      end else if (ctl.rx_feed) begin
        crc    <= crc_feed(crc, rx_byte);
        coil_k <= 5'd0;
        if (rx_count < CNT_W'(RX_DEPTH)) begin
          rx_count <= rx_count + CNT_W'(1);
        end else begin
          rx_overflow <= 1'b1;
        end
      end else if (tx_fire) begin
        tx_idx <= tx_idx + 3'd1;
        if (tx_idx < 3'd6) begin
          crc <= crc_feed(crc, tx_b);
        end else if (tx_idx == 3'd7) begin
          crc <= CRC_INIT;
        end
      end

      if (coil_fire) begin
        coil_k <= coil_k + 5'd1;
      end
      if (status_fire) begin
        awaiting <= 1'b0;
      end

      if (tx_fire || coil_fire || status_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header bytes are kept in registers so the checks need no buffer read.
  always_ff @(posedge clk) begin
    if (ctl.rx_feed) begin
      if (rx_count == CNT_W'(0)) begin
        hdr_id <= rx_byte;
      end
      if (rx_count == CNT_W'(1)) begin
        hdr_fn <= rx_byte;
      end
      if (rx_count == CNT_W'(2)) begin
        hdr_count <= rx_byte;
      end
    end
    if (ctl.set_status) begin
      stat_code <= ctl.status_code;
    end
  end

  // Receive buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rx_feed && rx_count < CNT_W'(RX_DEPTH)) begin
      rx_store[rx_count[ADDR_W-1:0]] <= rx_byte;
    end
    if (ctl.coil_rd) begin
      rd_data <= rx_store[ADDR_W'(coil_k) + ADDR_W'(3)];
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (tx_fire) begin
      out_kind       <= KIND_TX;
      out_tx_byte    <= tx_b;
      out_coil_group <= 5'd0;
      out_coil_bits  <= 8'h00;
      out_status     <= STAT_OK;
      out_last       <= (tx_idx == 3'd7);
    end else if (coil_fire) begin
      out_kind       <= KIND_COIL;
      out_tx_byte    <= 8'h00;
      out_coil_group <= coil_k;
      out_coil_bits  <= coil_masked;
      out_status     <= STAT_OK;
      out_last       <= 1'b0;
    end else if (status_fire) begin
      out_kind       <= KIND_STATUS;
      out_tx_byte    <= 8'h00;
      out_coil_group <= 5'd0;
      out_coil_bits  <= 8'h00;
      out_status     <= stat_code;
      out_last       <= 1'b1;
    end
  end

endmodule

FILE: tb/sv/mrc_reply_scoreboard.sv
`timescale 1ns / 1ps

// Watches both word channels and the slave address port of the read-coils master.
// It predicts every result word from the accepted command words and checks the
// result channel against the oldest prediction.
module mrc_reply_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  mrc_item_if          item,
  mrc_result_if        result,
  output int           mismatches,
  output int           words_owed
);

  import mrc_pkg::*;

  localparam int FRAME_OVERHEAD = 5;
  localparam int SHOW_LIMIT     = 10;

  typedef struct {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic [4:0] coil_group;
    logic [7:0] coil_bits;
    status_t    status;
    logic       last;
  } out_word_t;

  out_word_t   owed_q[$];

  // Shadow of the block's exchange state.
  logic [7:0]  reply_buf [RX_DEPTH];
  int          reply_len;
  logic [15:0] reply_crc;
  logic [7:0]  coils_asked;
  logic        in_exchange;
  logic        reply_too_long;
  logic [7:0]  slave_addr;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  task automatic push_word(input kind_t kind, input logic [7:0] tx, input logic [4:0] grp,
                           input logic [7:0] bits, input status_t st, input logic last);
    out_word_t w;
    w.kind       = kind;
    w.tx_byte    = tx;
    w.coil_group = grp;
    w.coil_bits  = bits;
    w.status     = st;
    w.last       = last;
    owed_q.push_back(w);
  endtask

  task automatic close_exchange(input status_t st);
    push_word(KIND_STATUS, 8'h00, 5'd0, 8'h00, st, 1'b1);
    in_exchange = 1'b0;
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [7:0] addr,
                              input logic [7:0] qty, input logic [7:0] b, input logic lastb);
    logic [7:0]  req [8];
    logic [15:0] c;
    int          nbytes;
    int          left;
    logic [7:0]  bits;
    case (cmd)
      CMD_START: begin
        req[0] = slave_addr;
        req[1] = FN_READ_COILS;
        req[2] = 8'h00;
        req[3] = addr;
        req[4] = 8'h00;
        req[5] = qty;
        c = CRC_INIT;
        for (int i = 0; i < 6; i++) c = crc16_update(c, req[i]);
        req[6] = c[7:0];
        req[7] = c[15:8];
        for (int i = 0; i < 8; i++) push_word(KIND_TX, req[i], 5'd0, 8'h00, STAT_OK, i == 7);
        coils_asked    = qty;
        reply_len      = 0;
        reply_crc      = CRC_INIT;
        reply_too_long = 1'b0;
        in_exchange    = 1'b1;
      end
      CMD_TIMEOUT: begin
        if (in_exchange) close_exchange(STAT_TIMEOUT);
      end
      CMD_RX_BYTE: begin
        if (in_exchange) begin
          reply_crc = crc16_update(reply_crc, b);
          if (reply_len < RX_DEPTH) begin
            reply_buf[reply_len] = b;
            reply_len++;
          end else begin
            reply_too_long = 1'b1;
          end
          if (lastb) begin
            nbytes = (int'(coils_asked) + 7) / 8;
            if (reply_too_long) begin
              close_exchange(STAT_OVERFLOW);
            end else if (reply_len < FRAME_OVERHEAD) begin
              close_exchange(STAT_SHORT);
            end else if (reply_crc != 16'h0000) begin
              close_exchange(STAT_CRC);
            end else if (reply_buf[0] != slave_addr || reply_buf[1] != FN_READ_COILS) begin
              close_exchange(STAT_ID_FN);
            end else if (int'(reply_buf[2]) != nbytes ||
                         reply_len != nbytes + FRAME_OVERHEAD) begin
              close_exchange(STAT_BYTE_COUNT);
            end else begin
              // Coils past the requested quantity are cleared in the last group.
              for (int k = 0; k < nbytes; k++) begin
                left = int'(coils_asked) - 8 * k;
                bits = reply_buf[3 + k];
                if (left < 8) bits = bits & ((8'd1 << left) - 8'd1);
                push_word(KIND_COIL, 8'h00, 5'(k), bits, STAT_OK, 1'b0);
              end
              close_exchange(STAT_OK);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    out_word_t want;
    bit        bad;
    if (owed_q.size() == 0) begin
      if (mismatches < SHOW_LIMIT) begin
        $display("unexpected result word: kind=%0d tx=%02h grp=%0d bits=%02h st=%0d last=%0b",
                 result.kind, result.tx_byte, result.coil_group, result.coil_bits,
                 result.status, result.last);
      end
      mismatches++;
      return;
    end
    want = owed_q.pop_front();
    bad = (result.kind !== want.kind) || (result.tx_byte !== want.tx_byte) ||
          (result.coil_group !== want.coil_group) || (result.coil_bits !== want.coil_bits) ||
          (result.status !== want.status) || (result.last !== want.last);
    if (bad) begin
      if (mismatches < SHOW_LIMIT) begin
        $display("result word mismatch: want kind=%0d tx=%02h grp=%0d bits=%02h st=%0d last=%0b",
                 want.kind, want.tx_byte, want.coil_group, want.coil_bits, want.status,
                 want.last);
        $display("                      got  kind=%0d tx=%02h grp=%0d bits=%02h st=%0d last=%0b",
                 result.kind, result.tx_byte, result.coil_group, result.coil_bits,
                 result.status, result.last);
      end
      mismatches++;
    end
  endtask

  // A result word accepted at the same edge as a command word always belongs to
  // an earlier command, so the check runs before the new prediction.
  always @(posedge clk) begin
    if (rst) begin
      owed_q.delete();
      reply_len      = 0;
      reply_crc      = CRC_INIT;
      coils_asked    = 8'h00;
      in_exchange    = 1'b0;
      reply_too_long = 1'b0;
      slave_addr     = NODE_ADDR_RESET;
      mismatches     = 0;
    end else begin
      if (cfg_wr_en === 1'b1) slave_addr = cfg_wr_data;
      if (result.valid === 1'b1 && result.ready === 1'b1) check_word();
      if (item.valid === 1'b1 && item.ready === 1'b1) begin
        predict_item(item.cmd, item.start_addr, item.quantity, item.rx_byte, item.rx_last);
      end
    end
    words_owed <= owed_q.size();
  end

endmodule

FILE: tb/sv/modbus_rtu_read_coils_master_unit_test.sv
`timescale 1ns / 1ps

// Top of the read-coils master bench. It makes clock, reset, command words,
// slave address writes and receiver back-pressure; the scoreboard beside the
// block does all prediction and checking and reports its mismatch count here.
module modbus_rtu_read_coils_master_unit_test;

  import mrc_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The longest quiet stretch of the block after its last owed word: a final
  // reply byte with 32 coil groups is the slowest case, and this allows for it.
  localparam int SETTLE_CYCLES = 100;

  // Random command words per configuration phase, and the number of phases.
  localparam int PHASE_ITEMS = 30;
  localparam int PHASES      = 4;

  typedef enum int {
    RPL_OK,
    RPL_TIMEOUT,
    RPL_SHORT,
    RPL_CRC,
    RPL_ID,
    RPL_FN,
    RPL_COUNT,
    RPL_LENGTH,
    RPL_OVERFLOW,
    RPL_ABANDON
  } reply_mode_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  mrc_item_if   item_ch();
  mrc_result_if result_ch();

  int         mismatches;
  int         words_owed;

  // The bench's own copy of the slave address, used to build reply frames.
  logic [7:0] slave_addr;
  // When set, neither side idles; gives stretches of back-to-back words.
  bit         steady;
  // Command words sent that the block acts on; ignored words are not tallied.
  int         items_sent;
  int         overflows_sent;

  modbus_rtu_read_coils_master_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  mrc_reply_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch),
    .mismatches  (mismatches),
    .words_owed  (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs or never delivers an owed word.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Idle cycles drawn before each word on either side.
  function automatic int pick_gap();
    return steady ? 0 : int'($urandom_range(0, 3));
  endfunction

  // The receiver draws a stall before each result word, then holds ready high
  // until a word is taken. Ready only changes at falling edges.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Sends one command word. It is entered and left at a falling edge; valid is
  // only lowered when a gap is drawn, so back-to-back words keep it high with a
  // single assignment per edge.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] addr, input logic [7:0] qty,
                           input logic [7:0] b, input logic lastb, input bit tally);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.cmd        <= cmd;
    item_ch.start_addr <= addr;
    item_ch.quantity   <= qty;
    item_ch.rx_byte    <= b;
    item_ch.rx_last    <= lastb;
    item_ch.valid      <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    @(negedge clk);
    if (tally) items_sent++;
  endtask

  // A reply byte; the fields that only a start uses carry random bits.
  task automatic send_rx(input logic [7:0] b, input logic lastb);
    send_word(CMD_RX_BYTE, 8'($urandom), 8'($urandom), b, lastb, 1'b1);
  endtask

  task automatic send_timeout(input bit tally);
    send_word(CMD_TIMEOUT, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), tally);
  endtask

  // Words that must not disturb an idle block: a stray reply byte, a stray
  // timeout, or the unused command code.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_word(CMD_RX_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
      1: send_timeout(1'b0);
      default: send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                         1'b0);
    endcase
  endtask

  // One full exchange: a start word, then a reply shaped by mode. Well-formed
  // frames carry a correct CRC so that the later checks (address, function,
  // byte count) are reached; each broken mode spoils exactly one thing.
  task automatic run_exchange(input logic [7:0] addr, input logic [7:0] qty,
                              input reply_mode_t mode);
    logic [7:0]  frame[$];
    logic [15:0] c;
    int          nbytes;
    int          n;
    int          idx;
    int          target;
    nbytes = (int'(qty) + 7) / 8;
    send_word(CMD_START, addr, qty, 8'($urandom), 1'($urandom), 1'b1);
    case (mode)
      RPL_TIMEOUT: begin
        // A partial reply, then the line goes quiet.
        n = $urandom_range(0, 3);
        repeat (n) send_rx(8'($urandom), 1'b0);
        send_timeout(1'b1);
      end
      RPL_SHORT: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_rx(8'($urandom), i == n - 1);
      end
      RPL_ABANDON: begin
        // Leave the exchange open; the next start word replaces it.
        n = $urandom_range(0, 3);
        repeat (n) send_rx(8'($urandom), 1'b0);
      end
      default: begin
        frame.push_back(slave_addr);
        frame.push_back(FN_READ_COILS);
        frame.push_back(8'(nbytes));
        repeat (nbytes) frame.push_back(8'($urandom));
        case (mode)
          RPL_ID:    frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
          RPL_FN:    frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
          RPL_COUNT: frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
          RPL_LENGTH: begin
            // Count byte is right but one data byte is missing or extra.
            if (nbytes > 0 && $urandom_range(0, 1) == 1) void'(frame.pop_back());
            else frame.push_back(8'($urandom));
          end
          RPL_OVERFLOW: begin
            // Pad past the receive buffer; the CRC still covers every byte.
            target = $urandom_range(RX_DEPTH + 1, RX_DEPTH + 6);
            while (frame.size() + 2 < target) frame.push_back(8'($urandom));
          end
          default: ;
        endcase
        c = CRC_INIT;
        foreach (frame[i]) c = crc_feed(c, frame[i]);
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        if (mode == RPL_CRC) begin
          // Any single flipped bit breaks the CRC.
          idx = $urandom_range(0, frame.size() - 1);
          frame[idx] = frame[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < frame.size(); i++) send_rx(frame[i], i == frame.size() - 1);
      end
    endcase
  endtask

  // Lets the block run dry: every owed word delivered, then a quiet stretch
  // for work that owes nothing. Also used as the mid-run pause of the sender.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Slave address write; only ever issued after settle().
  task automatic write_node_addr(input logic [7:0] id);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    slave_addr  = id;
  endtask

  // Draws one random exchange. Most are good replies with random coil data;
  // the rest spread over every failure path. Quantities stay small except for
  // an occasional near-full read, and at most two overflow frames are sent
  // since each one is some 65 reply bytes long.
  task automatic random_exchange();
    int          pick;
    logic [7:0]  qty;
    reply_mode_t mode;
    pick = $urandom_range(0, 99);
    qty  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(200, 255))
                                        : 8'($urandom_range(0, 40));
    if (pick < 52)      mode = RPL_OK;
    else if (pick < 58) mode = RPL_TIMEOUT;
    else if (pick < 63) mode = RPL_SHORT;
    else if (pick < 69) mode = RPL_CRC;
    else if (pick < 74) mode = RPL_ID;
    else if (pick < 78) mode = RPL_FN;
    else if (pick < 83) mode = RPL_COUNT;
    else if (pick < 88) mode = RPL_LENGTH;
    else if (pick < 91) mode = (overflows_sent < 2) ? RPL_OVERFLOW : RPL_OK;
    else if (pick < 96) mode = RPL_ABANDON;
    else begin
      send_noise();
      return;
    end
    if (mode == RPL_OVERFLOW) overflows_sent++;
    run_exchange(8'($urandom), qty, mode);
  endtask

  initial begin
    int phase_goal;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_START;
    item_ch.start_addr = 8'h00;
    item_ch.quantity   = 8'h00;
    item_ch.rx_byte    = 8'h00;
    item_ch.rx_last    = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 8'h00;
    rst                = 1'b1;
    slave_addr         = NODE_ADDR_RESET;
    steady             = 1'b0;
    items_sent         = 0;
    overflows_sent     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with the slave address still at its reset value.
    // Stray words before any request must produce nothing.
    send_word(CMD_RX_BYTE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_timeout(1'b0);
    send_word(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // Largest address and quantity, ended by a timeout.
    run_exchange(8'hFF, 8'hFF, RPL_TIMEOUT);
    // Zero quantity: a good reply carries no coil groups, only the ok status.
    run_exchange(8'h00, 8'h00, RPL_OK);
    // Fewer than five reply bytes.
    run_exchange(8'h5A, 8'd9, RPL_SHORT);
    // A start while a reply is pending drops the old exchange.
    run_exchange(8'hA5, 8'd3, RPL_ABANDON);
    run_exchange(8'h80, 8'd1, RPL_TIMEOUT);
    settle();

    // Random part in phases, each behind its own slave address: both extremes,
    // a random one, and the reset value again. The third phase runs without
    // any idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_node_addr(8'h00);
        1:       write_node_addr(8'hFF);
        2:       write_node_addr(8'($urandom));
        default: write_node_addr(NODE_ADDR_RESET);
      endcase
      steady     = (p == 2);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) random_exchange();
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0 && words_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_if.sv
hw/rtl/mrc_ctrl.sv
hw/rtl/mrc_dp.sv
hw/rtl/modbus_rtu_read_coils_master_unit.sv
tb/sv/mrc_reply_scoreboard.sv
tb/sv/modbus_rtu_read_coils_master_unit_test.sv
